### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the power-spectrum block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/pscon_pkg.sv
// Package for the power-spectrum contraction block: payload types, codes,
// fixed widths and the normalisation table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pscon_pkg;

  localparam int N_MAX_DEF = 16;
  localparam int L_MAX_DEF = 15;

  localparam int COEF_W  = 32;
  localparam int WORD_W  = 2 * COEF_W;
  localparam int OUT_W   = 48;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int OPD_W   = COEF_W + 1;
  localparam int PROD_W  = 2 * OPD_W;
  localparam int MAG_W   = 63;

  localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [1:0] MODE_QUERY       = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NORM_ON = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 1'd1;

  localparam logic [CFG_W-1:0] SCALE_RESET = 32'd65536;

  localparam int unsigned PREF_FRAC  = 28;
  localparam int unsigned SCALE_FRAC = 16;
  localparam logic [31:0] PREF_ONE   = 32'd1 << PREF_FRAC;
  localparam logic [63:0] PREF_K     = 64'd2385254615;
  localparam int PREF_DEPTH = 16;

  // K squared over 2l+1, for l from 15 down to 0.
  localparam logic [63:0] PREF_KK = PREF_K * PREF_K;
  localparam logic [PREF_DEPTH-1:0][63:0] PREF_SQ = {
    PREF_KK / 64'd31, PREF_KK / 64'd29, PREF_KK / 64'd27, PREF_KK / 64'd25,
    PREF_KK / 64'd23, PREF_KK / 64'd21, PREF_KK / 64'd19, PREF_KK / 64'd17,
    PREF_KK / 64'd15, PREF_KK / 64'd13, PREF_KK / 64'd11, PREF_KK / 64'd9,
    PREF_KK / 64'd7,  PREF_KK / 64'd5,  PREF_KK / 64'd3,  PREF_KK / 64'd1
  };

  typedef struct packed {
    logic        [1:0]        mode;
    logic        [3:0]        radial_n;
    logic        [3:0]        radial_k;
    logic        [7:0]        lm_index;
    logic        [3:0]        degree;
    logic signed [COEF_W-1:0] re;
    logic signed [COEF_W-1:0] im;
  } cmd_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_re;
    logic signed [OUT_W-1:0] out_im;
    logic                    saturated;
  } result_t;

  // Operands and products of the four shared multipliers.
  typedef struct packed {
    logic [3:0][OPD_W-1:0] a;
    logic [3:0][OPD_W-1:0] b;
  } mul_ops_t;

  typedef logic [3:0][PROD_W-1:0] mul_prod_t;

  typedef logic [PREF_DEPTH-1:0][31:0] pref_tab_t;

  // sqrt(8 pi^2 / (2l+1)) in unsigned Q4.28, rounded to nearest.
  // Evaluated at elaboration only.
  function automatic pref_tab_t pref_table_gen();
    pref_tab_t       tab;
    longint unsigned x;
    longint unsigned v;
    longint unsigned res;
    longint unsigned bits;
    for (int l = 0; l < PREF_DEPTH; l++) begin
      x    = PREF_SQ[l];
      v    = x;
      res  = 0;
      bits = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (v >= res + bits) begin
          v   = v - (res + bits);
          res = (res >> 1) + bits;
        end else begin
          res = res >> 1;
        end
        bits = bits >> 2;
      end
      if (x - res * res > res) begin
        res = res + 1;
      end
      tab[l] = res[31:0];
    end
    return tab;
  endfunction

  localparam pref_tab_t PREF_TABLE = pref_table_gen();

endpackage

`default_nettype wire

### rtl/pscon_ram.sv
// Coefficient store: one write port and one registered read port.
// Depends on pscon_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module pscon_ram
  import pscon_pkg::*;
#(
  parameter int DEPTH  = N_MAX_DEF * (L_MAX_DEF + 1) * (L_MAX_DEF + 1),
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/pscon_mul4.sv
// Shared arithmetic unit: four signed 33 x 33 multipliers with registered products.
// Depends on pscon_pkg for the operand and product types.
`timescale 1ns / 1ps
`default_nettype none

module pscon_mul4
  import pscon_pkg::*;
(
  input  logic      clk,
  input  mul_ops_t  ops,
  output mul_prod_t prod
);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      prod[i] <= $signed(ops.a[i]) * $signed(ops.b[i]);
    end
  end

endmodule

`default_nettype wire

### rtl/power_spectrum_contraction.sv
// Top level of the power-spectrum contraction block: sequencer, accumulator,
// rounding and saturation. Depends on pscon_pkg, pscon_ram, pscon_mul4, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// The block holds two stores of complex Q8.23 coefficients and answers
// queries X(n,k,l) = pref(l) * scale * sum over m of q1(n,lm) * conj(q2(k,lm)).
// A load transfer (mode 0 or 1) writes one element in the cycle it is taken
// and leaves busy low, so loads may be issued on every clock between queries.
// A query keeps busy high while it runs, and its result appears with done
// in the first cycle in which busy is low again. The length of a query, which
// grows with its degree, is set by the single read port of each store, which
// delivers one coefficient pair per cycle to one complex multiply-accumulate,
// followed by two passes of the same four multipliers for the normalisation
// and the scale factor. A query outside the configured range returns a zero
// result on the next cycle without going busy; an out-of-range load or an
// unused mode is dropped silently. Every result is held for exactly one cycle
// with done high: there is no back-pressure, so the receiver must take each
// transfer as it comes. Configuration writes are taken on any cycle with
// cfg_we high and must only be issued while no query is outstanding. The
// stores are not cleared by reset; a query that touches an element which
// was never loaded returns an unspecified value.
module power_spectrum_contraction
  import pscon_pkg::*;
#(
  parameter int N_MAX = N_MAX_DEF,
  parameter int L_MAX = L_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cmd_t                 cmd,
  output result_t              result,
  output logic                 done,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int LM_COUNT    = (L_MAX + 1) * (L_MAX + 1);
  localparam int STORE_DEPTH = N_MAX * LM_COUNT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int M_W         = $clog2(2 * L_MAX + 2);
  localparam int TERM_W      = 42;
  localparam int ACC_W       = TERM_W + M_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MAC      = 3'd1;
  localparam logic [2:0] S_PREF_MUL = 3'd2;
  localparam logic [2:0] S_PREF_RND = 3'd3;
  localparam logic [2:0] S_SCL_MUL  = 3'd4;
  localparam logic [2:0] S_SCL_RND  = 3'd5;

  localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(64'd1 << 62);
  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'd1 << (OUT_W - 1));
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [OUT_W-1:0] val;
    logic                    sat;
  } clip_t;

  // Product of two 33-bit signed values, rounded half away from zero by 23 bits.
  function automatic logic signed [40:0] rnd23(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    logic signed [40:0] m;
    mag = p[PROD_W-1] ? (~p + PROD_W'(1)) : p;
    q   = (mag + (PROD_W'(1) << 22)) >> 23;
    m   = 41'(q);
    return p[PROD_W-1] ? -m : m;
  endfunction

  // Joins the low and high partial products, rounds by s bits (half up on the
  // magnitude) and caps the magnitude at 2^62.
  function automatic logic [MAG_W-1:0] round_shift(input logic [63:0] plo,
                                                   input logic [63:0] phi,
                                                   input int unsigned s);
    logic [95:0] full;
    logic [95:0] q;
    full = {32'd0, plo} + {phi, 32'd0} + (96'd1 << (s - 1));
    q    = full >> s;
    if (q > 96'(MAG_CAP)) begin
      return MAG_CAP;
    end
    return q[MAG_W-1:0];
  endfunction

  function automatic clip_t clip48(input logic [MAG_W-1:0] q, input logic neg);
    clip_t             c;
    logic [OUT_W-1:0]  m;
    m     = q[OUT_W-1:0];
    c.sat = 1'b0;
    if (!neg && q > POS_LIM) begin
      c.val = OUT_MAX;
      c.sat = 1'b1;
    end else if (neg && q > NEG_LIM) begin
      c.val = OUT_MIN;
      c.sat = 1'b1;
    end else begin
      c.val = neg ? -m : m;
    end
    return c;
  endfunction

  // Control state.
  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [M_W-1:0] cnt;
  logic           rd_v;
  logic           prd_v;
  logic           trm_v;
  logic           norm_on;
  logic [CFG_W-1:0] scale;

  // Query context, captured when the query transfer is taken.
  logic [ADDR_W-1:0] base1;
  logic [ADDR_W-1:0] base2;
  logic [M_W-1:0]    last_m;
  logic [31:0]       pref_q;
  logic [31:0]       scale_mag;

  // Datapath.
  logic signed [TERM_W-1:0] term_re;
  logic signed [TERM_W-1:0] term_im;
  logic signed [ACC_W-1:0]  acc_re;
  logic signed [ACC_W-1:0]  acc_im;
  logic [ACC_W-1:0]         amag_re;
  logic [ACC_W-1:0]         amag_im;
  logic [MAG_W-1:0]         vmag_re;
  logic [MAG_W-1:0]         vmag_im;
  logic                     vneg_re;
  logic                     vneg_im;
  clip_t                    clip_re;
  clip_t                    clip_im;

  logic              accept;
  logic              ld_ok;
  logic              q_ok;
  logic              we1;
  logic              we2;
  logic              q_go;
  logic              q_oor;
  logic              issue;
  logic [ADDR_W-1:0] ld_addr;
  logic [ADDR_W-1:0] qb1;
  logic [ADDR_W-1:0] qb2;
  logic [WORD_W-1:0] rdata1;
  logic [WORD_W-1:0] rdata2;
  mul_ops_t          ops;
  mul_prod_t         prod;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Range checks and store addresses for the incoming transfer.
  assign ld_ok = (int'(cmd.radial_n) < N_MAX) && (int'(cmd.lm_index) < LM_COUNT);
  assign q_ok  = (int'(cmd.radial_n) < N_MAX) && (int'(cmd.radial_k) < N_MAX) &&
                 (int'(cmd.degree) <= L_MAX);

  assign ld_addr = ADDR_W'(int'(cmd.radial_n) * LM_COUNT + int'(cmd.lm_index));
  assign qb1     = ADDR_W'(int'(cmd.radial_n) * LM_COUNT +
                           int'(cmd.degree) * int'(cmd.degree));
  assign qb2     = ADDR_W'(int'(cmd.radial_k) * LM_COUNT +
                           int'(cmd.degree) * int'(cmd.degree));

  always_comb begin
    we1   = 1'b0;
    we2   = 1'b0;
    q_go  = 1'b0;
    q_oor = 1'b0;
    if (accept) begin
      unique case (cmd.mode)
        MODE_LOAD_FIRST:  we1 = ld_ok;
        MODE_LOAD_SECOND: we2 = ld_ok;
        MODE_QUERY: begin
          q_go  = q_ok;
          q_oor = !q_ok;
        end
        default: ;
      endcase
    end
  end

  // One coefficient pair is fetched per cycle while the m index is in range.
  assign issue = (state == S_MAC) && (cnt <= last_m);

  pscon_ram #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_first_store (
    .clk   (clk),
    .we    (we1),
    .waddr (ld_addr),
    .wdata ({cmd.re, cmd.im}),
    .raddr (base1 + ADDR_W'(cnt)),
    .rdata (rdata1)
  );

  pscon_ram #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_second_store (
    .clk   (clk),
    .we    (we2),
    .waddr (ld_addr),
    .wdata ({cmd.re, cmd.im}),
    .raddr (base2 + ADDR_W'(cnt)),
    .rdata (rdata2)
  );

  assign amag_re = acc_re[ACC_W-1] ? -acc_re : acc_re;
  assign amag_im = acc_im[ACC_W-1] ? -acc_im : acc_im;

  // Operand selection for the shared multipliers. During accumulation they
  // form the four real products of one complex term; afterwards each part
  // is split into a low 32-bit and a high slice against a common factor.
  always_comb begin
    unique case (state)
      S_PREF_MUL: begin
        ops.a[0] = {1'b0, amag_re[31:0]};
        ops.a[1] = OPD_W'(amag_re[ACC_W-1:32]);
        ops.a[2] = {1'b0, amag_im[31:0]};
        ops.a[3] = OPD_W'(amag_im[ACC_W-1:32]);
        for (int i = 0; i < 4; i++) begin
          ops.b[i] = {1'b0, pref_q};
        end
      end
      S_SCL_MUL: begin
        ops.a[0] = {1'b0, vmag_re[31:0]};
        ops.a[1] = OPD_W'(vmag_re[MAG_W-1:32]);
        ops.a[2] = {1'b0, vmag_im[31:0]};
        ops.a[3] = OPD_W'(vmag_im[MAG_W-1:32]);
        for (int i = 0; i < 4; i++) begin
          ops.b[i] = {1'b0, scale_mag};
        end
      end
      default: begin
        // a = first set element, b = second set element: re in the upper half.
        ops.a[0] = {rdata1[63], rdata1[63:32]};
        ops.b[0] = {rdata2[63], rdata2[63:32]};
        ops.a[1] = {rdata1[31], rdata1[31:0]};
        ops.b[1] = {rdata2[31], rdata2[31:0]};
        ops.a[2] = {rdata1[31], rdata1[31:0]};
        ops.b[2] = {rdata2[63], rdata2[63:32]};
        ops.a[3] = {rdata1[63], rdata1[63:32]};
        ops.b[3] = {rdata2[31], rdata2[31:0]};
      end
    endcase
  end

  pscon_mul4 u_mul (
    .clk  (clk),
    .ops  (ops),
    .prod (prod)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (q_go) state_next = S_MAC;
      S_MAC:      if (!issue && !rd_v && !prd_v && !trm_v) state_next = S_PREF_MUL;
      S_PREF_MUL: state_next = S_PREF_RND;
      S_PREF_RND: state_next = S_SCL_MUL;
      S_SCL_MUL:  state_next = S_SCL_RND;
      S_SCL_RND:  state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      rd_v    <= 1'b0;
      prd_v   <= 1'b0;
      trm_v   <= 1'b0;
      done    <= 1'b0;
      norm_on <= 1'b0;
      scale   <= SCALE_RESET;
    end else begin
      state <= state_next;
      rd_v  <= issue;
      prd_v <= rd_v;
      trm_v <= prd_v;
      done  <= q_oor || (state == S_SCL_RND);
      if (q_go) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + M_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NORM_ON: norm_on <= cfg_data[0];
          REG_SCALE:   scale   <= cfg_data;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_go) begin
      base1     <= qb1;
      base2     <= qb2;
      last_m    <= M_W'({cmd.degree, 1'b0});
      pref_q    <= norm_on ? PREF_TABLE[cmd.degree] : PREF_ONE;
      scale_mag <= scale[CFG_W-1] ? -scale : scale;
      acc_re    <= '0;
      acc_im    <= '0;
    end else if (trm_v) begin
      acc_re <= acc_re + ACC_W'(term_re);
      acc_im <= acc_im + ACC_W'(term_im);
    end

    // Complex term q1 * conj(q2), each real product rounded on its own.
    term_re <= TERM_W'(rnd23(prod[0])) + TERM_W'(rnd23(prod[1]));
    term_im <= TERM_W'(rnd23(prod[2])) - TERM_W'(rnd23(prod[3]));

    if (state == S_PREF_RND) begin
      vmag_re <= round_shift(prod[0][63:0], prod[1][63:0], PREF_FRAC);
      vmag_im <= round_shift(prod[2][63:0], prod[3][63:0], PREF_FRAC);
      vneg_re <= acc_re[ACC_W-1];
      vneg_im <= acc_im[ACC_W-1];
    end

    if (q_oor) begin
      result <= '0;
    end else if (state == S_SCL_RND) begin
      result.out_re    <= clip_re.val;
      result.out_im    <= clip_im.val;
      result.saturated <= clip_re.sat || clip_im.sat;
    end
  end

  assign clip_re = clip48(round_shift(prod[0][63:0], prod[1][63:0], SCALE_FRAC),
                          vneg_re ^ scale[CFG_W-1]);
  assign clip_im = clip48(round_shift(prod[2][63:0], prod[3][63:0], SCALE_FRAC),
                          vneg_im ^ scale[CFG_W-1]);

  // A result only follows the final rounding step or a rejected query.
  `ASSERT_IMPL(a_done_source, done, ($past(state) == S_SCL_RND) || $past(q_oor))
  // Accumulation must not be left while coefficient pairs are still in flight.
  `ASSERT_IMPL(a_mac_drained, (state == S_MAC) && (state_next != S_MAC), !rd_v && !prd_v && !trm_v)
  // The block only goes busy on an in-range query.
  `ASSERT_IMPL(a_busy_cause, $rose(busy), $past(q_go))
  // A saturated result has at least one part on a rail.
  `ASSERT_IMPL(a_sat_rail, done && result.saturated, (result.out_re == OUT_MAX) || (result.out_re == OUT_MIN) || (result.out_im == OUT_MAX) || (result.out_im == OUT_MIN))

endmodule

`default_nettype wire

### tb/sv/power_spectrum_contraction_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the power-spectrum contraction block: mirrors both coefficient
// stores and the two registers, works out every query result and compares it.
// Depends on pscon_pkg for the payload types, widths and register codes.
module power_spectrum_contraction_checker
  import pscon_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  cmd_t                 cmd,
  input  result_t              result,
  input  logic                 done,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   error_count,
  output int                   outstanding
);

  localparam int              LM_COUNT    = (L_MAX_DEF + 1) * (L_MAX_DEF + 1);
  localparam int              STORE_DEPTH = N_MAX_DEF * LM_COUNT;
  localparam longint          OUT_HI      = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint          OUT_LO      = -(64'sd1 <<< (OUT_W - 1));
  localparam longint unsigned MAG_CAP     = 64'd1 << 62;

  logic [WORD_W-1:0] q1_store [STORE_DEPTH];
  logic [WORD_W-1:0] q2_store [STORE_DEPTH];
  logic              norm_on;
  logic [CFG_W-1:0]  scale;
  longint unsigned   degree_norm [L_MAX_DEF + 1];
  result_t           pending_contractions [$];
  result_t           oldest;
  int                err_cnt = 0;

  assign error_count = err_cnt;

  // Nearest integer square root: bisection for the floor root, then round.
  function automatic longint unsigned nearest_root(longint unsigned x);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'hFFFF_FFFF;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid <= x) lo = mid;
      else hi = mid - 1;
    end
    if (x - lo * lo > lo) lo = lo + 1;
    return lo;
  endfunction

  // Q8.23 times Q8.23, brought back to Q.23 with rounding half away from zero.
  function automatic longint product_q23(longint a, longint b);
    longint          p;
    longint unsigned m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + (64'd1 << 22)) >> 23;
    return (p < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Product rounded by s bits, half away from zero, magnitude capped at 2^62.
  function automatic longint scale_round(longint a, longint b, int unsigned s);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] q;
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    q  = (ma * mb + (128'd1 << (s - 1))) >> s;
    if (q > 128'(MAG_CAP)) q = 128'(MAG_CAP);
    return ((a < 0) != (b < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint clip_out(longint v);
    if (v > OUT_HI) return OUT_HI;
    if (v < OUT_LO) return OUT_LO;
    return v;
  endfunction

  // Contraction over all orders m of one degree, then normalisation and scale.
  function automatic result_t contraction_result(cmd_t c);
    result_t           r;
    longint            acc_re;
    longint            acc_im;
    longint            ar, ai, br, bi;
    longint            v_re;
    longint            v_im;
    longint            factor;
    int                base;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    r = '0;
    if (c.radial_n >= N_MAX_DEF || c.radial_k >= N_MAX_DEF || c.degree > L_MAX_DEF)
      return r;
    acc_re = 0;
    acc_im = 0;
    base   = int'(c.degree) * int'(c.degree);
    for (int m = 0; m <= 2 * int'(c.degree); m++) begin
      w1 = q1_store[int'(c.radial_n) * LM_COUNT + base + m];
      w2 = q2_store[int'(c.radial_k) * LM_COUNT + base + m];
      ar = $signed(w1[WORD_W-1:COEF_W]);
      ai = $signed(w1[COEF_W-1:0]);
      br = $signed(w2[WORD_W-1:COEF_W]);
      bi = $signed(w2[COEF_W-1:0]);
      acc_re += product_q23(ar, br) + product_q23(ai, bi);
      acc_im += product_q23(ai, br) - product_q23(ar, bi);
    end
    factor = norm_on ? longint'(degree_norm[c.degree]) : longint'(PREF_ONE);
    v_re = scale_round(scale_round(acc_re, factor, PREF_FRAC), $signed(scale), SCALE_FRAC);
    v_im = scale_round(scale_round(acc_im, factor, PREF_FRAC), $signed(scale), SCALE_FRAC);
    r.saturated = (clip_out(v_re) != v_re) || (clip_out(v_im) != v_im);
    v_re = clip_out(v_re);
    v_im = clip_out(v_im);
    r.out_re = v_re[OUT_W-1:0];
    r.out_im = v_im[OUT_W-1:0];
    return r;
  endfunction

  initial begin
    for (int l = 0; l <= L_MAX_DEF; l++)
      degree_norm[l] = nearest_root((PREF_K * PREF_K) / 64'(2 * l + 1));
  end

  always @(posedge clk) begin
    if (rst) begin
      norm_on = 1'b0;
      scale   = SCALE_RESET;
      pending_contractions.delete();
    end else begin
      if (done) begin
        if (pending_contractions.size() == 0) begin
          err_cnt++;
          $display("%0t: result with none expected: re %0d im %0d sat %0b",
                   $time, result.out_re, result.out_im, result.saturated);
        end else begin
          oldest = pending_contractions.pop_front();
          if (oldest !== result) begin
            err_cnt++;
            $display("%0t: mismatch: expected re %0d im %0d sat %0b, actual re %0d im %0d sat %0b",
                     $time, oldest.out_re, oldest.out_im, oldest.saturated,
                     result.out_re, result.out_im, result.saturated);
          end
        end
      end
      if (start && !busy) begin
        case (cmd.mode)
          MODE_LOAD_FIRST: begin
            if (cmd.radial_n < N_MAX_DEF && cmd.lm_index < LM_COUNT)
              q1_store[int'(cmd.radial_n) * LM_COUNT + int'(cmd.lm_index)] = {cmd.re, cmd.im};
          end
          MODE_LOAD_SECOND: begin
            if (cmd.radial_n < N_MAX_DEF && cmd.lm_index < LM_COUNT)
              q2_store[int'(cmd.radial_n) * LM_COUNT + int'(cmd.lm_index)] = {cmd.re, cmd.im};
          end
          MODE_QUERY: pending_contractions.push_back(contraction_result(cmd));
          default: ;
        endcase
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_NORM_ON: norm_on = cfg_data[0];
          REG_SCALE:   scale   = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= pending_contractions.size();
  end

endmodule

### tb/sv/power_spectrum_contraction_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the power-spectrum contraction block: clock, reset,
// stimulus and verdict. Depends on pscon_pkg, the block and its checker module.
module power_spectrum_contraction_tb;
  import pscon_pkg::*;

  // The fourth mode code has no meaning; the block must drop such transfers.
  localparam logic [1:0]        MODE_UNUSED = 2'd3;
  localparam int                LM_COUNT    = (L_MAX_DEF + 1) * (L_MAX_DEF + 1);
  localparam int                ITEM_TARGET = 1950;
  localparam int                PHASES      = 8;
  // The slowest correct run is about 2000 degree-15 queries, each behind the
  // longest gap. The limit allows five times the length of such a run.
  localparam int                CYCLE_LIMIT = 1_000_000;
  localparam logic [COEF_W-1:0] COEF_MIN    = {1'b1, {(COEF_W - 1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_MAX    = {1'b0, {(COEF_W - 1){1'b1}}};

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  cmd_t                 cmd;
  result_t              result;
  logic                 done;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   error_count;
  int                   outstanding;

  // Transfers taken by the block, not counting those of the unused mode.
  int items_sent  = 0;
  int cycle_count = 0;
  // While set, the sender issues transfers back to back.
  bit no_gaps     = 1'b0;
  // Which store entries have been written. A query is only ever issued once
  // every entry it reads has been loaded, since unwritten entries are undefined.
  bit q1_loaded [N_MAX_DEF * LM_COUNT];
  bit q2_loaded [N_MAX_DEF * LM_COUNT];

  power_spectrum_contraction u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .result    (result),
    .done      (done),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  power_spectrum_contraction_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .result      (result),
    .done        (done),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A hung block must not stall the run for ever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Gaps between transfers are mostly absent or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Coefficients: full-range random values for the most part, with the
  // extremes and small magnitudes of either sign mixed in.
  function automatic logic signed [COEF_W-1:0] coef_value();
    logic signed [COEF_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = COEF_MIN;
          1: v = COEF_MAX;
          2: v = '0;
          default: v = '1;
        endcase
      end
      1, 2: begin
        v = $urandom_range(0, 1 << 24);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Low degrees dominate so that queries stay cheap; the top degrees still
  // turn up regularly.
  function automatic logic [3:0] pick_degree();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 4'($urandom_range(0, 3));
    if (r < 95) return 4'($urandom_range(4, 10));
    return 4'($urandom_range(11, 15));
  endfunction

  // Fields that a load does not use are filled at random all the same.
  function automatic cmd_t load_item(logic [1:0] op, logic [3:0] n, logic [7:0] lm);
    cmd_t c;
    c.mode     = op;
    c.radial_n = n;
    c.radial_k = 4'($urandom);
    c.lm_index = lm;
    c.degree   = 4'($urandom);
    c.re       = coef_value();
    c.im       = coef_value();
    return c;
  endfunction

  function automatic cmd_t query_item(logic [3:0] n, logic [3:0] k, logic [3:0] l);
    cmd_t c;
    c.mode     = MODE_QUERY;
    c.radial_n = n;
    c.radial_k = k;
    c.lm_index = 8'($urandom);
    c.degree   = l;
    c.re       = $urandom;
    c.im       = $urandom;
    return c;
  endfunction

  function automatic bit block_ready(logic [3:0] n, logic [3:0] k, logic [3:0] l);
    int base;
    base = int'(l) * int'(l);
    for (int m = 0; m <= 2 * int'(l); m++) begin
      if (!q1_loaded[int'(n) * LM_COUNT + base + m]) return 1'b0;
      if (!q2_loaded[int'(k) * LM_COUNT + base + m]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // One transfer. Start is raised with the payload and stays high until the
  // block takes it on an edge where busy is low. With no gap to follow it is
  // left high, so the next call simply replaces the payload in the same step.
  task automatic send_item(input cmd_t c);
    int g;
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (c.mode == MODE_LOAD_FIRST) q1_loaded[int'(c.radial_n) * LM_COUNT + int'(c.lm_index)] = 1'b1;
    if (c.mode == MODE_LOAD_SECOND) q2_loaded[int'(c.radial_n) * LM_COUNT + int'(c.lm_index)] = 1'b1;
    if (c.mode != MODE_UNUSED) items_sent++;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Hold off until every query result has come back. The first edge lets the
  // checker's count catch up with a transfer taken on the current edge.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The write enable drops for a cycle after each write, so that two writes
  // in a row never assign it twice in one time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Scale setting per phase: unity, both extremes, zero, minus one, a random
  // full-range value and a random small one.
  function automatic logic [CFG_W-1:0] scale_setting(int p);
    case (p)
      0, 1: return SCALE_RESET;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h0000_0000;
      5: return 32'hFFFF_0000;
      6: return $urandom;
      default: return $urandom_range(0, 1 << 18);
    endcase
  endfunction

  // A well-formed sequence: load both operand blocks of one degree, reloading
  // some entries that already hold data, then ask for the contraction.
  task automatic run_contraction(input logic [3:0] n, input logic [3:0] k, input logic [3:0] l);
    int idx;
    for (int m = 0; m <= 2 * int'(l); m++) begin
      idx = int'(l) * int'(l) + m;
      if (!q1_loaded[int'(n) * LM_COUNT + idx] || $urandom_range(0, 2) == 0)
        send_item(load_item(MODE_LOAD_FIRST, n, 8'(idx)));
      if (!q2_loaded[int'(k) * LM_COUNT + idx] || $urandom_range(0, 2) == 0)
        send_item(load_item(MODE_LOAD_SECOND, k, 8'(idx)));
    end
    send_item(query_item(n, k, l));
  endtask

  // Noise: stray loads anywhere, transfers of the unused mode, queries on
  // whatever happens to be fully loaded, and load sequences left unfinished.
  task automatic send_noise();
    logic [3:0] n;
    logic [3:0] k;
    logic [3:0] l;
    int         count;
    n = 4'($urandom);
    k = 4'($urandom);
    l = pick_degree();
    case ($urandom_range(0, 3))
      0: send_item(load_item($urandom_range(0, 1) ? MODE_LOAD_SECOND : MODE_LOAD_FIRST,
                             n, 8'($urandom)));
      1: send_item(load_item(MODE_UNUSED, n, 8'($urandom)));
      2: begin
        if (block_ready(n, k, l)) send_item(query_item(n, k, l));
        else send_item(load_item(MODE_LOAD_SECOND, k, 8'($urandom)));
      end
      default: begin
        count = $urandom_range(0, 2 * int'(l));
        for (int m = 0; m <= count; m++)
          send_item(load_item(MODE_LOAD_FIRST, n, 8'(int'(l) * int'(l) + m)));
      end
    endcase
  endtask

  // Directed opening: extreme coefficients at degree zero, the highest radial
  // index and last element of the highest degree, a transfer of the unused
  // mode that must leave the stores alone, and a degree-one query across the
  // two extreme radial indices.
  task automatic directed_items();
    cmd_t c;
    c = load_item(MODE_LOAD_FIRST, 4'd0, 8'd0);
    c.re = COEF_MAX;
    c.im = COEF_MIN;
    send_item(c);
    c = load_item(MODE_LOAD_SECOND, 4'd0, 8'd0);
    c.re = COEF_MIN;
    c.im = COEF_MAX;
    send_item(c);
    send_item(query_item(4'd0, 4'd0, 4'd0));
    // Most negative times most negative in every one of the four products.
    c = load_item(MODE_LOAD_FIRST, 4'd0, 8'd0);
    c.re = COEF_MIN;
    c.im = COEF_MIN;
    send_item(c);
    c.mode = MODE_LOAD_SECOND;
    send_item(c);
    send_item(query_item(4'd0, 4'd0, 4'd0));
    c = load_item(MODE_LOAD_FIRST, 4'd15, 8'd255);
    c.re = '0;
    c.im = COEF_MAX;
    send_item(c);
    c = load_item(MODE_LOAD_SECOND, 4'd15, 8'd255);
    c.re = COEF_MAX;
    c.im = COEF_MAX;
    send_item(c);
    // An unused-mode transfer shaped like a load of entry zero: the query that
    // follows must still see the values loaded above.
    c = load_item(MODE_UNUSED, 4'd0, 8'd0);
    c.re = '1;
    c.im = '1;
    send_item(c);
    send_item(query_item(4'd0, 4'd0, 4'd0));
    for (int m = 1; m <= 3; m++) begin
      send_item(load_item(MODE_LOAD_FIRST, 4'd15, 8'(m)));
      send_item(load_item(MODE_LOAD_SECOND, 4'd0, 8'(m)));
    end
    c = query_item(4'd15, 4'd0, 4'd1);
    c.lm_index = '1;
    c.re       = '1;
    c.im       = '1;
    send_item(c);
  endtask

  // Eight phases, each under its own register setting. Registers are only
  // written with the block idle: after reset, and once a phase has drained.
  // Every phase runs a full degree-15 sequence before it mixes well-formed
  // sequences with noise and switches back-to-back bursts on and off.
  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    cmd       <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_NORM_ON, CFG_W'(p % 2));
      write_reg(REG_SCALE, scale_setting(p));
      if (p == 0) directed_items();
      run_contraction(4'($urandom), 4'($urandom), 4'd15);
      while (items_sent < (p + 1) * ITEM_TARGET / PHASES) begin
        if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
        if ($urandom_range(0, 4) == 0) send_noise();
        else run_contraction(4'($urandom), 4'($urandom), pick_degree());
      end
      wait_drained();
    end
    // Nothing should arrive now; give a stray result time to show itself.
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
